/* sv/frm_pkg.sv */
// frm_pkg: shared types and constants of the frame rate monitor
// used by the channel interfaces, the serial divider and the top level
// no dependencies
`default_nettype none

package frm_pkg;

   // field widths of the channels
   localparam int unsigned STAMP_W  = 40;
   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned MEM_W    = 40;
   localparam int unsigned RATE_W   = 10;
   localparam int unsigned STAT_W   = 16;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MODE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 8'd1;

   // reset values of the configuration registers, and the target used when it is zero
   localparam logic [1:0] ENABLE_RESET = 2'd0;
   localparam logic [7:0] TARGET_RESET = 8'd60;
   localparam logic [7:0] TARGET_DEFAULT = 8'd60;

   // rate arithmetic
   localparam logic [RATE_W-1:0] RATE_MAX = 10'd999;
   localparam int unsigned RATE_DIVIDEND = 1000;
   localparam int unsigned PERCENT = 100;
   localparam int unsigned SPEED_NUM = 21;
   localparam int unsigned SPEED_DEN = 20;

   // serial divider geometry
   localparam int unsigned DIVIDEND_W = 64;
   localparam int unsigned DIVISOR_W  = 32;
   localparam int unsigned STEP_W     = 7;
   localparam logic [STEP_W-1:0] RATE_STEPS  = 7'd10;
   localparam logic [STEP_W-1:0] SCORE_STEPS = 7'd40;
   localparam logic [STEP_W-1:0] MEM_STEPS   = 7'd64;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

/* sv/frm_if.sv */
// frm_if: valid/ready channel interfaces of the frame rate monitor
// request, response and register write channels
// depends on frm_pkg
`default_nettype none

interface frm_req_if;
   logic                          valid;
   logic                          ready;
   logic [frm_pkg::STAMP_W-1:0]   now_ms;
   logic [frm_pkg::PHASE_W-1:0]   input_phase_ms;
   logic [frm_pkg::MEM_W-1:0]     mem_bytes;
   logic                          mem_valid;

   modport source (output valid, now_ms, input_phase_ms, mem_bytes, mem_valid,
                   input ready);
   modport sink   (input valid, now_ms, input_phase_ms, mem_bytes, mem_valid,
                   output ready);
endinterface

interface frm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [frm_pkg::RATE_W-1:0]    rate_now;
   logic [frm_pkg::STAT_W-1:0]    rate_average;
   logic [frm_pkg::RATE_W-1:0]    rate_worst;
   logic [frm_pkg::STAT_W-1:0]    rate_score;
   logic [frm_pkg::STAT_W-1:0]    drop_count;
   logic [frm_pkg::PHASE_W-1:0]   input_worst_ms;
   logic [frm_pkg::MEM_W-1:0]     mem_peak_out;
   logic [frm_pkg::MEM_W-1:0]     mem_average_out;
   logic                          window_closed;

   modport source (output valid, rate_now, rate_average, rate_worst, rate_score,
                   drop_count, input_worst_ms, mem_peak_out, mem_average_out,
                   window_closed, input ready);
   modport sink   (input valid, rate_now, rate_average, rate_worst, rate_score,
                   drop_count, input_worst_ms, mem_peak_out, mem_average_out,
                   window_closed, output ready);
endinterface

interface frm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [frm_pkg::CSR_IDX_W-1:0]   index;
   logic [frm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/frm_div.sv */
// frm_div: restoring serial divider, one quotient bit per cycle
// 64-bit dividend, 32-bit divisor, step count chosen per start
// depends on frm_pkg
`default_nettype none

module frm_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire frm_pkg::div_ctrl_type       ctrl,
   input  wire [frm_pkg::DIVIDEND_W-1:0]    dividend,
   input  wire [frm_pkg::DIVISOR_W-1:0]     divisor,
   output frm_pkg::div_stat_type            stat,
   output logic [frm_pkg::DIVIDEND_W-1:0]   quotient
);
   import frm_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, dq_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};

      rem_in     = rem_ff;
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (ctrl.start) begin
         // dividend bits sit at the top so the msb of the work comes first
         rem_in     = '0;
         dq_in      = dividend << (STEP_W'(DIVIDEND_W) - ctrl.steps);
         divisor_in = divisor;
         cnt_in     = ctrl.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dq_in  = {dq_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

endmodule

`default_nettype wire

/* sv/frame_rate_monitor_core.sv */
// frame_rate_monitor_core: per-frame rate and memory statistics over timed windows
// one frame beat in, one statistics beat out, all divisions on frm_div
// depends on frm_pkg, frm_if, frm_div
//
//   channel   dir   handshake        carries
//   req_ch    in    valid/ready      now_ms, input_phase_ms, mem_bytes, mem_valid
//   rsp_ch    out   valid/ready      rates, score, drops, input worst, memory stats
//   csr_ch    in    valid/ready      register index and data, always ready
//
// per frame: a disabled or first frame goes straight to the response; an ordinary
// frame runs a rate division of 10 divider steps, skipped when the rate needs no
// division; window close adds a score division of 40 steps and a memory average
// division of 64 steps, all on the one serial divider, the latter skipped when the window saw no memory sample
// a new request is taken only while the sequencer is idle
// the response sits in an output register; a stalled response blocks only the
// final hand-over, so the next request may already be taken
// reset is synchronous and clears all statistics, no clearing pass
`default_nettype none

module frame_rate_monitor_core #(
   parameter int unsigned WINDOW_MS  = 1000,
   parameter int unsigned TIME_WIDTH = 40
) (
   input  wire        clock,
   input  wire        reset,
   frm_req_if.sink    req_ch,
   frm_rsp_if.source  rsp_ch,
   frm_csr_if.sink    csr_ch
);
   import frm_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_PREP      = 9'b000000010,
      ST_RATE_DIV  = 9'b000000100,
      ST_UPDATE    = 9'b000001000,
      ST_CLOSE     = 9'b000010000,
      ST_SCORE_DIV = 9'b000100000,
      ST_MEM_DIV   = 9'b001000000,
      ST_CLEAR     = 9'b010000000,
      ST_RESP      = 9'b100000000
   } state_type;

   function automatic logic [STAT_W-1:0] sat16(input logic [DIVIDEND_W-1:0] v);
      sat16 = (|v[DIVIDEND_W-1:STAT_W]) ? {STAT_W{1'b1}} : v[STAT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [1:0]             enable_ff, enable_in;
   logic [7:0]             target_ff, target_in;

   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic [MEM_W-1:0]       mem_ff, mem_in;
   logic                   mem_ok_ff, mem_ok_in;
   logic                   win_due_ff, win_due_in;
   logic                   closed_ff, closed_in;

   logic [31:0]            frames_ff, frames_in;
   logic [TIME_WIDTH-1:0]  last_ff, last_in;
   logic [TIME_WIDTH-1:0]  wstart_ff, wstart_in;
   logic [RATE_W-1:0]      rate_now_ff, rate_now_in;
   logic [STAT_W-1:0]      rate_avg_ff, rate_avg_in;
   logic [RATE_W-1:0]      rate_worst_ff, rate_worst_in;
   logic [STAT_W-1:0]      score_ff, score_in;
   logic [STAT_W-1:0]      drops_ff, drops_in;
   logic [31:0]            good_ff, good_in;
   logic [RATE_W-1:0]      wworst_ff, wworst_in;
   logic [31:0]            wdrops_ff, wdrops_in;
   logic [PHASE_W-1:0]     iw_cur_ff, iw_cur_in;
   logic [PHASE_W-1:0]     iw_lat_ff, iw_lat_in;
   logic [MEM_W-1:0]       mpeak_ff, mpeak_in;
   logic [MEM_W-1:0]       mavg_ff, mavg_in;
   logic [63:0]            msum_ff, msum_in;
   logic [31:0]            msamp_ff, msamp_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]      o_rate_now_ff, o_rate_now_in;
   logic [STAT_W-1:0]      o_rate_avg_ff, o_rate_avg_in;
   logic [RATE_W-1:0]      o_rate_worst_ff, o_rate_worst_in;
   logic [STAT_W-1:0]      o_score_ff, o_score_in;
   logic [STAT_W-1:0]      o_drops_ff, o_drops_in;
   logic [PHASE_W-1:0]     o_iw_ff, o_iw_in;
   logic [MEM_W-1:0]       o_mpeak_ff, o_mpeak_in;
   logic [MEM_W-1:0]       o_mavg_ff, o_mavg_in;
   logic                   o_closed_ff, o_closed_in;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;
   logic [DIVIDEND_W-1:0]  div_dividend;
   logic [DIVISOR_W-1:0]   div_divisor;
   logic [DIVIDEND_W-1:0]  div_quot;

   logic [TIME_WIDTH-1:0]  now_t;
   logic [TIME_WIDTH-1:0]  frame_diff;
   logic [TIME_WIDTH-1:0]  win_diff;
   logic [31:0]            period_ms;
   logic [7:0]             target_eff;
   logic [STAT_W:0]        drop_ref;
   logic [STAT_W-1:0]      avg_sat;
   logic [20:0]            speed_lhs;
   logic [20:0]            speed_rhs;
   logic [22:0]            avg_pct;
   logic [38:0]            good_pct;

   assign now_t         = TIME_WIDTH'(req_ch.now_ms);
   assign frame_diff    = now_ff - last_ff;
   assign win_diff      = now_ff - wstart_ff;
   assign period_ms     = frame_diff[31:0];
   assign target_eff    = (target_ff != 8'd0) ? target_ff : TARGET_DEFAULT;
   assign drop_ref      = (rate_avg_ff != '0) ? {1'b0, rate_avg_ff}
                                              : (STAT_W+1)'(target_eff);
   assign avg_sat       = sat16(DIVIDEND_W'(frames_ff));
   assign speed_lhs     = 21'(avg_sat) * 21'(SPEED_DEN);
   assign speed_rhs     = 21'(target_eff) * 21'(SPEED_NUM);
   assign avg_pct       = 23'(avg_sat) * 23'(PERCENT);
   assign good_pct      = 39'(good_ff) * 39'(PERCENT);

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      target_in     = target_ff;
      now_in        = now_ff;
      mem_in        = mem_ff;
      mem_ok_in     = mem_ok_ff;
      win_due_in    = win_due_ff;
      closed_in     = closed_ff;
      frames_in     = frames_ff;
      last_in       = last_ff;
      wstart_in     = wstart_ff;
      rate_now_in   = rate_now_ff;
      rate_avg_in   = rate_avg_ff;
      rate_worst_in = rate_worst_ff;
      score_in      = score_ff;
      drops_in      = drops_ff;
      good_in       = good_ff;
      wworst_in     = wworst_ff;
      wdrops_in     = wdrops_ff;
      iw_cur_in     = iw_cur_ff;
      iw_lat_in     = iw_lat_ff;
      mpeak_in      = mpeak_ff;
      mavg_in       = mavg_ff;
      msum_in       = msum_ff;
      msamp_in      = msamp_ff;

      rsp_valid_in    = rsp_valid_ff;
      o_rate_now_in   = o_rate_now_ff;
      o_rate_avg_in   = o_rate_avg_ff;
      o_rate_worst_in = o_rate_worst_ff;
      o_score_in      = o_score_ff;
      o_drops_in      = o_drops_ff;
      o_iw_in         = o_iw_ff;
      o_mpeak_in      = o_mpeak_ff;
      o_mavg_in       = o_mavg_ff;
      o_closed_in     = o_closed_ff;

      div_ctrl      = '0;
      div_dividend  = '0;
      div_divisor   = '0;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ENABLE_MODE: enable_in = csr_ch.data[1:0];
            CSR_TARGET_RATE: target_in = csr_ch.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               now_in    = now_t;
               mem_in    = req_ch.mem_bytes;
               mem_ok_in = req_ch.mem_valid;
               closed_in = 1'b0;
               if (enable_ff == 2'd0) begin
                  state_in = ST_RESP;
               end else begin
                  if (req_ch.input_phase_ms > iw_cur_ff) begin
                     iw_cur_in = req_ch.input_phase_ms;
                  end
                  frames_in = frames_ff + 32'd1;
                  // first frame seeds both stamps instead of measuring a rate
                  if (last_ff == '0) begin
                     last_in   = now_t;
                     wstart_in = now_t;
                     state_in  = ST_RESP;
                  end else begin
                     state_in  = ST_PREP;
                  end
               end
            end
         end
         ST_PREP: begin
            last_in    = now_ff;
            win_due_in = win_diff >= TIME_WIDTH'(WINDOW_MS);
            if (period_ms == 32'd0) begin
               rate_now_in = RATE_MAX;
               state_in    = ST_UPDATE;
            end else if (|period_ms[31:RATE_W]) begin
               // frame of 1024 ms or more gives rate zero without a division
               rate_now_in = '0;
               state_in    = ST_UPDATE;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.steps = RATE_STEPS;
               div_dividend   = DIVIDEND_W'(RATE_DIVIDEND);
               div_divisor    = DIVISOR_W'(period_ms[RATE_W-1:0]);
               state_in       = ST_RATE_DIV;
            end
         end
         ST_RATE_DIV: begin
            if (div_stat.done) begin
               rate_now_in = (div_quot[RATE_W-1:0] > RATE_MAX) ? RATE_MAX
                                                              : div_quot[RATE_W-1:0];
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if ((RATE_W+1)'(rate_now_ff) + (RATE_W+1)'(1) >= (RATE_W+1)'(target_eff)) begin
               good_in = good_ff + 32'd1;
            end
            if ((STAT_W+1)'(rate_now_ff) + (STAT_W+1)'(2) < drop_ref) begin
               wdrops_in = wdrops_ff + 32'd1;
            end
            if (wworst_ff == '0 || rate_now_ff < wworst_ff) begin
               wworst_in = rate_now_ff;
            end
            if (mem_ok_ff) begin
               if (mem_ff > mpeak_ff) begin
                  mpeak_in = mem_ff;
               end
               msum_in  = msum_ff + 64'(mem_ff);
               msamp_in = msamp_ff + 32'd1;
            end
            state_in = win_due_ff ? ST_CLOSE : ST_RESP;
         end
         ST_CLOSE: begin
            rate_avg_in    = avg_sat;
            rate_worst_in  = wworst_ff;
            drops_in       = sat16(DIVIDEND_W'(wdrops_ff));
            iw_lat_in      = iw_cur_ff;
            div_ctrl.start = 1'b1;
            div_ctrl.steps = SCORE_STEPS;
            // speed above 105 percent scores against the target
            if (speed_lhs > speed_rhs) begin
               div_dividend = DIVIDEND_W'(avg_pct);
               div_divisor  = DIVISOR_W'(target_eff);
            end else begin
               div_dividend = DIVIDEND_W'(good_pct);
               div_divisor  = (frames_ff != 32'd0) ? frames_ff : 32'd1;
            end
            state_in = ST_SCORE_DIV;
         end
         ST_SCORE_DIV: begin
            if (div_stat.done) begin
               score_in = sat16(div_quot);
               if (msamp_ff != 32'd0) begin
                  div_ctrl.start = 1'b1;
                  div_ctrl.steps = MEM_STEPS;
                  div_dividend   = msum_ff;
                  div_divisor    = msamp_ff;
                  state_in       = ST_MEM_DIV;
               end else begin
                  state_in       = ST_CLEAR;
               end
            end
         end
         ST_MEM_DIV: begin
            if (div_stat.done) begin
               mavg_in  = div_quot[MEM_W-1:0];
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            frames_in = '0;
            wstart_in = now_ff;
            wworst_in = '0;
            good_in   = '0;
            wdrops_in = '0;
            iw_cur_in = '0;
            msum_in   = '0;
            msamp_in  = '0;
            closed_in = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               o_rate_now_in   = rate_now_ff;
               o_rate_avg_in   = rate_avg_ff;
               o_rate_worst_in = rate_worst_ff;
               o_score_in      = score_ff;
               o_drops_in      = drops_ff;
               o_iw_in         = iw_lat_ff;
               o_mpeak_in      = mpeak_ff;
               o_mavg_in       = mavg_ff;
               o_closed_in     = closed_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      mem_ff          <= mem_in;
      mem_ok_ff       <= mem_ok_in;
      win_due_ff      <= win_due_in;
      closed_ff       <= closed_in;
      o_rate_now_ff   <= o_rate_now_in;
      o_rate_avg_ff   <= o_rate_avg_in;
      o_rate_worst_ff <= o_rate_worst_in;
      o_score_ff      <= o_score_in;
      o_drops_ff      <= o_drops_in;
      o_iw_ff         <= o_iw_in;
      o_mpeak_ff      <= o_mpeak_in;
      o_mavg_ff       <= o_mavg_in;
      o_closed_ff     <= o_closed_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= ENABLE_RESET;
         target_ff     <= TARGET_RESET;
         frames_ff     <= '0;
         last_ff       <= '0;
         wstart_ff     <= '0;
         rate_now_ff   <= '0;
         rate_avg_ff   <= '0;
         rate_worst_ff <= '0;
         score_ff      <= '0;
         drops_ff      <= '0;
         good_ff       <= '0;
         wworst_ff     <= '0;
         wdrops_ff     <= '0;
         iw_cur_ff     <= '0;
         iw_lat_ff     <= '0;
         mpeak_ff      <= '0;
         mavg_ff       <= '0;
         msum_ff       <= '0;
         msamp_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         target_ff     <= target_in;
         frames_ff     <= frames_in;
         last_ff       <= last_in;
         wstart_ff     <= wstart_in;
         rate_now_ff   <= rate_now_in;
         rate_avg_ff   <= rate_avg_in;
         rate_worst_ff <= rate_worst_in;
         score_ff      <= score_in;
         drops_ff      <= drops_in;
         good_ff       <= good_in;
         wworst_ff     <= wworst_in;
         wdrops_ff     <= wdrops_in;
         iw_cur_ff     <= iw_cur_in;
         iw_lat_ff     <= iw_lat_in;
         mpeak_ff      <= mpeak_in;
         mavg_ff       <= mavg_in;
         msum_ff       <= msum_in;
         msamp_ff      <= msamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   frm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.rate_now        = o_rate_now_ff;
   assign rsp_ch.rate_average    = o_rate_avg_ff;
   assign rsp_ch.rate_worst      = o_rate_worst_ff;
   assign rsp_ch.rate_score      = o_score_ff;
   assign rsp_ch.drop_count      = o_drops_ff;
   assign rsp_ch.input_worst_ms  = o_iw_ff;
   assign rsp_ch.mem_peak_out    = o_mpeak_ff;
   assign rsp_ch.mem_average_out = o_mavg_ff;
   assign rsp_ch.window_closed   = o_closed_ff;

endmodule

`default_nettype wire

/* sv/frm_checker.sv */
// frm_checker: port-level checks of the frame rate monitor
// bound to frame_rate_monitor_core, sees its ports only
// depends on frm_pkg
`default_nettype none

module frm_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [frm_pkg::RATE_W-1:0]    rate_now,
   input wire [frm_pkg::RATE_W-1:0]    rate_worst,
   input wire [frm_pkg::STAT_W-1:0]    rate_score
);
   import frm_pkg::*;

   // a response beat stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // stalled response rate_now and rate_score do not move
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rate_now) && $stable(rate_score))
      else $error("response payload changed while stalled");

   // the sequencer is busy after taking a frame beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on back-to-back cycles");

   // immediate and worst rates saturate below one thousand
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rate_now <= RATE_MAX && rate_worst <= RATE_MAX)
      else $error("rate beyond saturation limit");

endmodule

bind frame_rate_monitor_core frm_checker u_frm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rate_now   (rsp_ch.rate_now),
   .rate_worst (rsp_ch.rate_worst),
   .rate_score (rsp_ch.rate_score)
);

`default_nettype wire
